// ----- rtl/srma_pkg.sv -----
// Shared types and codes for the sensor room moving average block.
package srma_pkg;

  localparam logic [1:0] KIND_MAP     = 2'd0;
  localparam logic [1:0] KIND_READING = 2'd1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_DUP      = 2'd3;

  typedef enum logic [1:0] {
    OP_MAP,
    OP_READ,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [15:0]        sensor;
    logic [15:0]        room_id;
    logic signed [15:0] temperature;
    logic [31:0]        timestamp;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_DECIDE,
    B_OLD,
    B_UPD,
    B_DIVSET,
    B_DIV,
    B_FIN
  } bstate_t;

endpackage

// ----- rtl/srma_front.sv -----
// Front end: accepts stream transactions, classifies them and queues them.
module srma_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [1:0]          s_axis_tuser,   // kind
  input  logic [79:0]         s_axis_tdata,   // sensor, room_id, temperature, timestamp
  output logic                q_valid,
  output srma_pkg::item_t     q_item,
  input  logic                q_ready
);

  srma_pkg::item_t fifo_mem [2];
  srma_pkg::item_t in_item;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  always_comb begin
    case (s_axis_tuser)
      srma_pkg::KIND_MAP:     in_item.op = srma_pkg::OP_MAP;
      srma_pkg::KIND_READING: in_item.op = srma_pkg::OP_READ;
      default:                in_item.op = srma_pkg::OP_QUERY;
    endcase
    in_item.sensor      = s_axis_tdata[15:0];
    in_item.room_id     = s_axis_tdata[31:16];
    in_item.temperature = s_axis_tdata[47:32];
    in_item.timestamp   = s_axis_tdata[79:48];
  end

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid & s_axis_tready;
  assign q_valid       = (count != 2'd0);
  assign pop           = q_valid & q_ready;
  assign q_item        = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

// ----- rtl/srma_back.sv -----
// Back end: table search, window update, mean divider and output register.
module srma_back #(
  parameter int TABLE_ENTRIES = 16,
  parameter int WINDOW_LEN    = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  srma_pkg::item_t q_item,
  output logic            q_ready,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [1:0]      m_axis_tuser,   // status
  output logic [71:0]     m_axis_tdata    // room_out, average, sample_count, last_time, pad
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int HW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FW = $clog2(WINDOW_LEN + 1);
  localparam int SW = 17 + $clog2(WINDOW_LEN);
  localparam int NS = TABLE_ENTRIES * WINDOW_LEN;
  localparam int AW = (NS > 1) ? $clog2(NS) : 1;
  localparam int CW = $clog2(SW + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [FW-1:0] W_FILL   = FW'(WINDOW_LEN);
  localparam logic [HW:0]   W_POS    = (HW + 1)'(WINDOW_LEN);

  // table record memories, read at the scan index, written at the hit index
  logic [15:0]        m_sensor [TABLE_ENTRIES];
  logic [15:0]        m_room   [TABLE_ENTRIES];
  logic [SW-1:0]      m_sum    [TABLE_ENTRIES];
  logic [FW-1:0]      m_fill   [TABLE_ENTRIES];
  logic [HW-1:0]      m_head   [TABLE_ENTRIES];
  logic [31:0]        m_time   [TABLE_ENTRIES];
  logic [15:0]        smp_mem  [NS];
  logic [TABLE_ENTRIES-1:0] entry_valid;

  srma_pkg::bstate_t state, state_next;
  srma_pkg::item_t   cur;

  logic [IW-1:0] idx, cmp_idx, hit_idx, free_idx;
  logic          cmp_v, hit, free_ok;
  logic [15:0]   rd_sensor, rd_room;
  logic [SW-1:0] rd_sum;
  logic [FW-1:0] rd_fill;
  logic [HW-1:0] rd_head;
  logic [31:0]   rd_time;

  logic [1:0]    status;
  logic [15:0]   rec_room;
  logic [SW-1:0] rec_sum;
  logic [FW-1:0] rec_fill;
  logic [HW-1:0] rec_head;
  logic [31:0]   rec_time;

  logic [AW-1:0] smp_addr, smp_a, addr_c;
  logic [15:0]   smp_rdata;
  logic          smp_we, rec_we;
  logic [HW:0]   pos_sum;
  logic [HW-1:0] pos, head_inc;
  logic [SW-1:0] temp_x, old_x;

  logic [SW-1:0] dq;
  logic [FW-1:0] drem;
  logic [CW-1:0] dcnt;
  logic          dneg;
  logic [FW:0]   rem_sh;
  logic          ge;
  logic [SW-1:0] avg_full;
  logic          out_free;

  logic          cmp_hit;

  assign temp_x  = {{(SW-16){cur.temperature[15]}}, cur.temperature};
  assign old_x   = {{(SW-16){smp_rdata[15]}}, smp_rdata};
  assign pos_sum = (HW + 1)'(rec_head) + (HW + 1)'(rec_fill);
  assign pos     = (rec_fill == W_FILL) ? rec_head :
                   (pos_sum >= W_POS) ? HW'(pos_sum - W_POS) : HW'(pos_sum);
  assign head_inc = ((HW + 1)'(pos) + (HW + 1)'(1) == W_POS) ? '0 : HW'(pos + HW'(1));
  assign addr_c  = AW'(hit_idx * AW'(WINDOW_LEN)) + AW'(pos);
  assign smp_a   = (state == srma_pkg::B_OLD) ? smp_addr : addr_c;
  assign cmp_hit = cmp_v && entry_valid[cmp_idx] && (rd_sensor == cur.sensor);
  assign rem_sh  = {drem, dq[SW-1]};
  assign ge      = rem_sh >= {1'b0, rec_fill};
  assign avg_full = dneg ? (~dq + SW'(1)) : dq;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    smp_we     = 1'b0;
    rec_we     = 1'b0;
    case (state)
      srma_pkg::B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_next = srma_pkg::B_SCAN;
      end
      srma_pkg::B_SCAN: begin
        if (cmp_hit || (cmp_v && cmp_idx == LAST_IDX)) state_next = srma_pkg::B_DECIDE;
      end
      srma_pkg::B_DECIDE: begin
        state_next = srma_pkg::B_DIVSET;
        if (cur.op == srma_pkg::OP_MAP) begin
          if (!hit && free_ok) state_next = srma_pkg::B_UPD;
        end else if (cur.op == srma_pkg::OP_READ && hit) begin
          if (rec_fill == W_FILL) begin
            state_next = srma_pkg::B_OLD;
          end else begin
            smp_we     = 1'b1;
            state_next = srma_pkg::B_UPD;
          end
        end
      end
      srma_pkg::B_OLD: begin
        smp_we     = 1'b1;
        state_next = srma_pkg::B_UPD;
      end
      srma_pkg::B_UPD: begin
        rec_we     = 1'b1;
        state_next = srma_pkg::B_DIVSET;
      end
      srma_pkg::B_DIVSET: begin
        state_next = (rec_fill == '0) ? srma_pkg::B_FIN : srma_pkg::B_DIV;
      end
      srma_pkg::B_DIV: begin
        if (dcnt == CW'(1)) state_next = srma_pkg::B_FIN;
      end
      srma_pkg::B_FIN: begin
        if (out_free) state_next = srma_pkg::B_IDLE;
      end
      default: state_next = srma_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= srma_pkg::B_IDLE;
    else     state <= state_next;
  end

  // record memories: registered read at the scan index
  always_ff @(posedge clk) begin
    if (rec_we) begin
      m_sensor[hit_idx] <= cur.sensor;
      m_room[hit_idx]   <= rec_room;
      m_sum[hit_idx]    <= rec_sum;
      m_fill[hit_idx]   <= rec_fill;
      m_head[hit_idx]   <= rec_head;
      m_time[hit_idx]   <= rec_time;
    end
    rd_sensor <= m_sensor[idx];
    rd_room   <= m_room[idx];
    rd_sum    <= m_sum[idx];
    rd_fill   <= m_fill[idx];
    rd_head   <= m_head[idx];
    rd_time   <= m_time[idx];
  end

  always_ff @(posedge clk) begin
    if (smp_we) smp_mem[smp_a] <= cur.temperature;
    smp_rdata <= smp_mem[smp_a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (rec_we) begin
      entry_valid[hit_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      srma_pkg::B_IDLE: begin
        cur     <= q_item;
        idx     <= '0;
        cmp_v   <= 1'b0;
        hit     <= 1'b0;
        free_ok <= 1'b0;
      end
      srma_pkg::B_SCAN: begin
        cmp_idx <= idx;
        cmp_v   <= 1'b1;
        if (idx != LAST_IDX) idx <= idx + IW'(1);
        if (cmp_hit) begin
          hit      <= 1'b1;
          hit_idx  <= cmp_idx;
          rec_room <= rd_room;
          rec_sum  <= rd_sum;
          rec_fill <= rd_fill;
          rec_head <= rd_head;
          rec_time <= rd_time;
        end else if (cmp_v && !entry_valid[cmp_idx] && !free_ok) begin
          free_ok  <= 1'b1;
          free_idx <= cmp_idx;
        end
      end
      srma_pkg::B_DECIDE: begin
        status <= srma_pkg::ST_OK;
        if (cur.op == srma_pkg::OP_MAP) begin
          if (hit) begin
            status <= srma_pkg::ST_DUP;
          end else begin
            status   <= free_ok ? srma_pkg::ST_OK : srma_pkg::ST_FULL;
            hit_idx  <= free_idx;
            rec_room <= free_ok ? cur.room_id : 16'd0;
            rec_sum  <= '0;
            rec_fill <= '0;
            rec_head <= '0;
            rec_time <= '0;
          end
        end else if (!hit) begin
          status   <= srma_pkg::ST_UNMAPPED;
          rec_room <= '0;
          rec_sum  <= '0;
          rec_fill <= '0;
          rec_time <= '0;
        end else if (cur.op == srma_pkg::OP_READ) begin
          if (cur.timestamp > rec_time) rec_time <= cur.timestamp;
          if (rec_fill == W_FILL) begin
            smp_addr <= addr_c;
            rec_head <= head_inc;
          end else begin
            rec_fill <= rec_fill + FW'(1);
            rec_sum  <= rec_sum + temp_x;
          end
        end
      end
      srma_pkg::B_OLD: begin
        rec_sum <= rec_sum - old_x + temp_x;
      end
      srma_pkg::B_DIVSET: begin
        dneg <= rec_sum[SW-1];
        dq   <= (rec_fill == '0) ? '0 : (rec_sum[SW-1] ? (~rec_sum + SW'(1)) : rec_sum);
        drem <= '0;
        dcnt <= CW'(SW);
      end
      srma_pkg::B_DIV: begin
        drem <= ge ? FW'(rem_sh - {1'b0, rec_fill}) : FW'(rem_sh);
        dq   <= {dq[SW-2:0], ge};
        dcnt <= dcnt - CW'(1);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == srma_pkg::B_FIN && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == srma_pkg::B_FIN && out_free) begin
      m_axis_tuser <= status;
      m_axis_tdata <= {5'd0, rec_time, 3'(rec_fill), avg_full[15:0], rec_room};
    end
  end

  a_upd_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == srma_pkg::B_UPD) |=> entry_valid[hit_idx])
    else $error("table write did not mark its entry valid");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == srma_pkg::B_DIV) |-> (rec_fill <= W_FILL) && (rec_fill != '0))
    else $error("divider started with a bad sample count");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == srma_pkg::B_FIN && out_free) |=> m_axis_tvalid && state == srma_pkg::B_IDLE)
    else $error("finished transaction not presented");

  a_idle_free: assert property (@(posedge clk) disable iff (rst)
    (state == srma_pkg::B_SCAN) |-> !q_ready)
    else $error("queue popped during a search");

endmodule

// ----- rtl/sensor_room_moving_average.sv -----
// Top level of the sensor room moving average block.
// Maps sensor ids to rooms in a table of TABLE_ENTRIES entries and keeps a
// window of the last WINDOW_LEN readings per mapped sensor. Each input
// transaction gives exactly one result transaction. Items queue in a
// two-deep buffer; the engine handles one item at a time: it takes the
// item from the queue, runs a search that reads one table entry per cycle
// (stopping early on a hit), updates the window, sets up the divider,
// runs a bit-serial divide (skipped for an empty window) and loads the
// result register, waiting first while the previous result waits on
// m_axis_tready.
// No clearing pass is needed after reset.
module sensor_room_moving_average #(
  parameter int TABLE_ENTRIES = 16,
  parameter int WINDOW_LEN    = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // kind
  input  logic [79:0] s_axis_tdata,   // sensor, room_id, temperature, timestamp
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,   // status
  output logic [71:0] m_axis_tdata    // room_out, average, sample_count, last_time, pad
);

  logic            q_valid;
  logic            q_ready;
  srma_pkg::item_t q_item;

  srma_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_ready       (q_ready)
  );

  srma_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .WINDOW_LEN    (WINDOW_LEN)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_ready       (q_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
